[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the modular exponentiation block.
// Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MME_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MME_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/mme_pkg.sv]
// Shared widths, types and command codes of the modular exponentiation block.
// No dependencies.
package mme_pkg;
  localparam int WORD_COUNT = 8;
  localparam int WORD_BITS  = 32;
  localparam int OP_W       = WORD_COUNT * WORD_BITS;
  localparam int PROD_W     = 2 * OP_W;
  localparam int WIDE_W     = PROD_W + WORD_BITS;
  localparam int FOLD_ROUNDS = 16;
  localparam int FOLD_WEIGHT = 19;
  localparam int OPERAND_DEPTH = 8 * WORD_COUNT;

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [2*WORD_BITS-1:0] dword_t;
  typedef logic [OP_W-1:0]        opnd_t;

  typedef enum logic [3:0] {
    CMD_BASE   = 4'd0,
    CMD_EXP    = 4'd1,
    CMD_MOD    = 4'd2,
    CMD_ACC    = 4'd3,
    CMD_FACTOR = 4'd4,
    CMD_BETA   = 4'd5,
    CMD_RMASK  = 4'd6,
    CMD_PN     = 4'd7,
    CMD_START  = 4'd8
  } cmd_e;

  localparam logic [2:0] OP_BASE   = 3'd0;
  localparam logic [2:0] OP_EXP    = 3'd1;
  localparam logic [2:0] OP_MOD    = 3'd2;
  localparam logic [2:0] OP_ACC    = 3'd3;
  localparam logic [2:0] OP_FACTOR = 3'd4;
  localparam logic [2:0] OP_BETA   = 3'd5;
  localparam logic [2:0] OP_RMASK  = 3'd6;
  localparam logic [2:0] OP_PN     = 3'd7;
endpackage

[rtl/mme_if.sv]
// Valid/ready channel interfaces for the command and result streams.
// Depends on mme_pkg.
interface mme_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        cmd;
  logic [2:0]        word_index;
  mme_pkg::word_t    operand_word;
  modport source (output valid, cmd, word_index, operand_word, input ready);
  modport sink (input valid, cmd, word_index, operand_word, output ready);
endinterface

interface mme_out_if;
  logic              valid;
  logic              ready;
  mme_pkg::word_t    result_word;
  logic [2:0]        result_index;
  logic              last;
  modport source (output valid, result_word, result_index, last, input ready);
  modport sink (input valid, result_word, result_index, last, output ready);
endinterface

[rtl/mme_mac.sv]
// Shared 32x32 multiply-accumulate unit: a*b + addend + carry_in.
// Depends on mme_pkg.
module mme_mac (
  input  mme_pkg::word_t  a,
  input  mme_pkg::word_t  b,
  input  mme_pkg::word_t  addend,
  input  mme_pkg::word_t  carry_in,
  output mme_pkg::dword_t sum
);
  import mme_pkg::*;
  dword_t prod;
  assign prod = dword_t'(a) * dword_t'(b);
  assign sum  = prod + dword_t'(addend) + dword_t'(carry_in);
endmodule

[rtl/montgomery_modexp_p25519.sv]
// Montgomery modular exponentiation over 256-bit operands loaded as 32-bit
// words; a start command runs the power and returns eight result words.
// Depends on mme_pkg, mme_if, mme_mac and assert_macros.svh.
//
// A start first sweeps the 64-word operand memory into working registers,
// then every 256x256 product runs on the single 32x32 multiply-accumulate
// unit, one word pair per cycle. A Montgomery reduction is two such products
// plus an add and a conditional subtract, the base conversion one product
// plus up to 16 fold rounds. Leading zero bits of the exponent run no
// products; from the top set bit down each bit squares the accumulator and
// a one bit also multiplies it by the converted base. Commands are not
// accepted while a run is busy or its eight result words are pending.
module montgomery_modexp_p25519 (
  input logic     clk,
  input logic     rst_n,
  mme_in_if.sink    in_ch,
  mme_out_if.source out_ch
);
  import mme_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MUL, S_FOLD_CHK, S_FOLD_Q, S_FOLD_ADD, S_FOLD_SUB,
    S_EXP, S_MR_INIT, S_MR_U, S_MR_ADD, S_MR_SUB, S_NEXT, S_OUT
  } state_t;

  typedef enum logic [1:0] {PH_BASE, PH_SQR, PH_MULB, PH_FINAL} phase_t;
  typedef enum logic [1:0] {MK_OPER, MK_BETA, MK_P} mulkind_t;

  state_t   state_r;
  phase_t   phase_r;
  mulkind_t kind_r;

  word_t               op_mem [OPERAND_DEPTH];
  word_t               rd_data_r;
  logic [6:0]          cnt_r;
  opnd_t               opr_r [8];
  opnd_t               mx_r, my_r, acc_r, bm_r, t_lo_unused;
  logic [PROD_W-1:0]   pb_r, t_r;
  logic [WIDE_W-1:0]   v_r, q19_r;
  word_t               c_r;
  logic [2:0]          i_r, j_r, k_r;
  logic [7:0]          bit_r;
  logic                started_r, bflag_r;
  logic [4:0]          round_r;
  logic                out_valid_r;
  word_t               out_word_r;
  logic [2:0]          out_idx_r;
  logic                out_last_r;

  dword_t              mac_sum;
  word_t               mac_carry;
  logic [3:0]          lo_idx;
  logic [5:0]          ld_addr;
  logic [OP_W:0]       h_val;
  logic                v_ge_p, h_ge_p, exp_bit;
  logic [WIDE_W-1:0]   q_ext, q19_val, v_masked;
  logic                in_xfer, out_xfer;

  assign t_lo_unused = '0;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_word  = out_word_r;
  assign out_ch.result_index = out_idx_r;
  assign out_ch.last         = out_last_r;

  assign lo_idx    = {1'b0, i_r} + {1'b0, j_r};
  assign ld_addr   = cnt_r[5:0] - 6'd1;
  assign mac_carry = (j_r == 3'd0) ? '0 : c_r;

  mme_mac u_mac (
    .a        (mx_r[i_r*WORD_BITS +: WORD_BITS]),
    .b        (my_r[j_r*WORD_BITS +: WORD_BITS]),
    .addend   (pb_r[lo_idx*WORD_BITS +: WORD_BITS]),
    .carry_in (mac_carry),
    .sum      (mac_sum)
  );

  assign v_ge_p   = (v_r >= {{(WIDE_W-OP_W){1'b0}}, opr_r[OP_MOD]});
  assign h_val    = v_r[PROD_W:OP_W];
  assign h_ge_p   = (h_val >= {1'b0, opr_r[OP_MOD]});
  assign exp_bit  = opr_r[OP_EXP][bit_r];
  assign q_ext    = {{(WIDE_W-(WIDE_W-1-OP_W+1)){1'b0}}, v_r[WIDE_W-2:OP_W-1]};
  assign q19_val  = (q_ext << 4) + (q_ext << 1) + q_ext;
  assign v_masked = {{(WIDE_W-OP_W){1'b0}}, v_r[OP_W-1:0] & opr_r[OP_PN]};

  always_ff @(posedge clk) begin
    if (in_xfer && !in_ch.cmd[3]) begin
      op_mem[{in_ch.cmd[2:0], in_ch.word_index}] <= in_ch.operand_word;
    end
    rd_data_r <= op_mem[cnt_r[5:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer && in_ch.cmd == CMD_START) begin
            cnt_r   <= '0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (cnt_r != 7'd0) begin
            opr_r[ld_addr[5:3]][ld_addr[2:0]*WORD_BITS +: WORD_BITS] <= rd_data_r;
          end
          if (cnt_r == 7'(OPERAND_DEPTH)) begin
            mx_r    <= opr_r[OP_BASE];
            my_r    <= opr_r[OP_FACTOR];
            pb_r    <= '0;
            i_r     <= '0;
            j_r     <= '0;
            phase_r <= PH_BASE;
            kind_r  <= MK_OPER;
            state_r <= S_MUL;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        S_MUL: begin
          c_r <= mac_sum[2*WORD_BITS-1:WORD_BITS];
          j_r <= j_r + 3'd1;
          if (j_r == 3'd7) begin
            pb_r[lo_idx*WORD_BITS +: 2*WORD_BITS] <= mac_sum;
            i_r <= i_r + 3'd1;
            if (i_r == 3'd7) begin
              case (kind_r)
                MK_BETA: state_r <= S_MR_U;
                MK_P:    state_r <= S_MR_ADD;
                default: begin
                  if (phase_r == PH_BASE) begin
                    round_r <= '0;
                    state_r <= S_FOLD_CHK;
                  end else begin
                    state_r <= S_MR_INIT;
                  end
                end
              endcase
            end
          end else begin
            pb_r[lo_idx*WORD_BITS +: WORD_BITS] <= mac_sum[WORD_BITS-1:0];
          end
        end
        S_FOLD_CHK: begin
          if (round_r == 5'd0) begin
            v_r     <= {{(WIDE_W-PROD_W){1'b0}}, pb_r};
            round_r <= 5'd1;
          end else if (round_r <= 5'(FOLD_ROUNDS + 1) - 5'd1 + 5'd1 - 5'd1
                       && round_r != 5'(FOLD_ROUNDS + 1) && v_ge_p) begin
            state_r <= S_FOLD_Q;
          end else begin
            bm_r      <= v_r[OP_W-1:0];
            acc_r     <= opr_r[OP_ACC];
            bit_r     <= 8'hff;
            started_r <= 1'b0;
            state_r   <= S_EXP;
          end
        end
        S_FOLD_Q: begin
          q19_r   <= q19_val;
          state_r <= S_FOLD_ADD;
        end
        S_FOLD_ADD: begin
          v_r     <= v_masked + q19_r;
          state_r <= S_FOLD_SUB;
        end
        S_FOLD_SUB: begin
          if (v_ge_p) begin
            v_r <= v_r - {{(WIDE_W-OP_W){1'b0}}, opr_r[OP_MOD]};
          end
          round_r <= round_r + 5'd1;
          state_r <= S_FOLD_CHK;
        end
        S_EXP: begin
          if (exp_bit || started_r) begin
            started_r <= 1'b1;
            bflag_r   <= exp_bit;
            mx_r      <= acc_r;
            my_r      <= acc_r;
            pb_r      <= '0;
            i_r       <= '0;
            j_r       <= '0;
            phase_r   <= PH_SQR;
            kind_r    <= MK_OPER;
            state_r   <= S_MUL;
          end else if (bit_r == 8'd0) begin
            pb_r    <= {{(PROD_W-OP_W){1'b0}}, acc_r};
            phase_r <= PH_FINAL;
            state_r <= S_MR_INIT;
          end else begin
            bit_r <= bit_r - 8'd1;
          end
        end
        S_MR_INIT: begin
          t_r     <= pb_r;
          mx_r    <= pb_r[OP_W-1:0] & opr_r[OP_RMASK];
          my_r    <= opr_r[OP_BETA];
          pb_r    <= '0;
          i_r     <= '0;
          j_r     <= '0;
          kind_r  <= MK_BETA;
          state_r <= S_MUL;
        end
        S_MR_U: begin
          mx_r    <= pb_r[OP_W-1:0] & opr_r[OP_RMASK];
          my_r    <= opr_r[OP_MOD];
          pb_r    <= '0;
          i_r     <= '0;
          j_r     <= '0;
          kind_r  <= MK_P;
          state_r <= S_MUL;
        end
        S_MR_ADD: begin
          v_r     <= {{(WIDE_W-PROD_W){1'b0}}, t_r} + {{(WIDE_W-PROD_W){1'b0}}, pb_r};
          state_r <= S_MR_SUB;
        end
        S_MR_SUB: begin
          if (h_ge_p) begin
            acc_r <= opnd_t'(h_val - {1'b0, opr_r[OP_MOD]});
          end else begin
            acc_r <= h_val[OP_W-1:0] | t_lo_unused;
          end
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (phase_r == PH_FINAL) begin
            k_r         <= 3'd1;
            out_word_r  <= acc_r[WORD_BITS-1:0];
            out_idx_r   <= 3'd0;
            out_last_r  <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else if (phase_r == PH_SQR && bflag_r) begin
            mx_r    <= acc_r;
            my_r    <= bm_r;
            pb_r    <= '0;
            i_r     <= '0;
            j_r     <= '0;
            phase_r <= PH_MULB;
            kind_r  <= MK_OPER;
            state_r <= S_MUL;
          end else if (bit_r == 8'd0) begin
            pb_r    <= {{(PROD_W-OP_W){1'b0}}, acc_r};
            phase_r <= PH_FINAL;
            state_r <= S_MR_INIT;
          end else begin
            bit_r   <= bit_r - 8'd1;
            state_r <= S_EXP;
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            if (out_last_r) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              out_word_r <= acc_r[k_r*WORD_BITS +: WORD_BITS];
              out_idx_r  <= k_r;
              out_last_r <= (k_r == 3'(WORD_COUNT - 1));
              k_r        <= k_r + 3'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `MME_ASSERT_IMPL(a_no_accept_while_out, clk, rst_n, out_valid_r, !in_ch.ready)
  `MME_ASSERT_IMPL(a_last_on_top, clk, rst_n, out_valid_r && out_last_r, out_idx_r == 3'd7)
  `MME_ASSERT_NEXT(a_idle_after_last, clk, rst_n, out_xfer && out_last_r, in_ch.ready)
  `MME_ASSERT_IMPL(a_fold_bounded, clk, rst_n, state_r == S_FOLD_Q, round_r <= 5'(FOLD_ROUNDS))
endmodule

[dv/tb.sv]
// Testbench for montgomery_modexp_p25519: loads operands, starts runs and
// checks every result word against a predictor built on 256-bit vectors.
// Depends on mme_pkg, mme_if and the RTL of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mme_pkg::*;

  typedef struct packed {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } power_word_t;

  class power_scoreboard;
    opnd_t         operands [8];
    power_word_t   expected_words [$];
    int            mismatches;

    function new();
      foreach (operands[k]) operands[k] = '0;
      mismatches = 0;
    endfunction

    function logic [PROD_W-1:0] wide_mul(opnd_t a, opnd_t b);
      return {{OP_W{1'b0}}, a} * {{OP_W{1'b0}}, b};
    endfunction

    function opnd_t mont_step(logic [PROD_W-1:0] t);
      opnd_t                  u;
      logic [PROD_W-1:0]      m;
      logic [PROD_W-1:0]      mp;
      logic [WIDE_W-1:0]      s;
      logic [WIDE_W-OP_W-1:0] h;
      logic [WIDE_W-OP_W-1:0] pw;
      u  = t[OP_W-1:0] & operands[OP_RMASK];
      m  = wide_mul(u, operands[OP_BETA]);
      u  = m[OP_W-1:0] & operands[OP_RMASK];
      mp = wide_mul(u, operands[OP_MOD]);
      s  = {{WORD_BITS{1'b0}}, t} + {{WORD_BITS{1'b0}}, mp};
      h  = s[WIDE_W-1:OP_W];
      pw = {{WORD_BITS{1'b0}}, operands[OP_MOD]};
      if (h >= pw) h = h - pw;
      return h[OP_W-1:0];
    endfunction

    function opnd_t fold_p25519(logic [PROD_W-1:0] t);
      logic [WIDE_W-1:0] v;
      logic [WIDE_W-1:0] q;
      logic [WIDE_W-1:0] pw;
      int                round;
      v  = {{(WIDE_W-PROD_W){1'b0}}, t};
      pw = {{(WIDE_W-OP_W){1'b0}}, operands[OP_MOD]};
      for (round = 0; round < FOLD_ROUNDS && v >= pw; round++) begin
        q = {{OP_W{1'b0}}, v[WIDE_W-2:OP_W-1]};
        q = q * WIDE_W'(FOLD_WEIGHT);
        v = {{(WIDE_W-OP_W){1'b0}}, v[OP_W-1:0] & operands[OP_PN]};
        v = v + q;
        if (v >= pw) v = v - pw;
      end
      return v[OP_W-1:0];
    endfunction

    function void note_transfer(logic [3:0] cmd, logic [2:0] idx, word_t value);
      logic [PROD_W-1:0] prod;
      opnd_t             base_m;
      opnd_t             acc;
      opnd_t             power;
      opnd_t             ex;
      bit                started;
      if (cmd < CMD_START) begin
        operands[cmd[2:0]][idx*WORD_BITS +: WORD_BITS] = value;
        return;
      end
      if (cmd != CMD_START) return;
      prod    = wide_mul(operands[OP_BASE], operands[OP_FACTOR]);
      base_m  = fold_p25519(prod);
      acc     = operands[OP_ACC];
      ex      = operands[OP_EXP];
      started = 0;
      for (int b = OP_W - 1; b >= 0; b--) begin
        if (ex[b]) started = 1;
        if (started) begin
          prod = wide_mul(acc, acc);
          acc  = mont_step(prod);
          if (ex[b]) begin
            prod = wide_mul(acc, base_m);
            acc  = mont_step(prod);
          end
        end
      end
      power = mont_step({{OP_W{1'b0}}, acc});
      for (int k = 0; k < WORD_COUNT; k++)
        expected_words.push_back('{power[k*WORD_BITS +: WORD_BITS], k[2:0],
                                   k == WORD_COUNT - 1});
    endfunction

    function void check_word(power_word_t got);
      power_word_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word %h index %0d", got.word, got.index);
        return;
      end
      want = expected_words.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %h/%0d/%b actual %h/%0d/%b",
                   want.word, want.index, want.last, got.word, got.index, got.last);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  mme_in_if  in_ch ();
  mme_out_if out_ch ();
  power_scoreboard sb = new();

  opnd_t p25519;
  opnd_t beta25519;
  int    results_seen = 0;
  int    idle_cycles = 0;
  bit    pressure_done = 0;

  montgomery_modexp_p25519 DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.cmd = '0;
    in_ch.word_index = '0;
    in_ch.operand_word = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 400000) begin
      $display("[montgomery_modexp_p25519] ERROR");
      $finish;
    end
  end

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic send(logic [3:0] cmd, logic [2:0] idx, word_t value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.cmd = cmd;
    in_ch.word_index = idx;
    in_ch.operand_word = value;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_transfer(cmd, idx, value);
    @(negedge clk);
  endtask

  task automatic load_operand(logic [3:0] cmd, opnd_t value);
    for (int k = 0; k < WORD_COUNT; k++)
      send(cmd, k[2:0], value[k*WORD_BITS +: WORD_BITS]);
  endtask

  function automatic opnd_t rand_opnd();
    opnd_t r;
    for (int k = 0; k < WORD_COUNT; k++) r[k*WORD_BITS +: WORD_BITS] = $urandom;
    return r;
  endfunction

  // hold the sink off for a long stretch once, in the middle of a run's words
  initial begin
    int hold;
    power_word_t got;
    wait (rst_n);
    forever begin
      hold = draw_gap();
      if (!pressure_done && results_seen == 41) begin
        hold = 600;
        pressure_done = 1;
      end
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready = 0;
        repeat (hold) @(negedge clk);
      end
      out_ch.ready = 1;
      do @(posedge clk); while (!out_ch.valid);
      got = '{out_ch.result_word, out_ch.result_index, out_ch.last};
      sb.check_word(got);
      results_seen++;
    end
  end

  initial begin
    opnd_t x;
    opnd_t standard [8];
    logic [3:0] cmd;
    logic [2:0] idx;
    int wait_left;
    p25519 = {1'b0, {255{1'b1}}} - 18;
    x = p25519;
    repeat (8) x = x * (2 - p25519 * x);
    beta25519 = -x;
    standard[OP_BASE]   = rand_opnd();
    standard[OP_EXP]    = '0;
    standard[OP_MOD]    = p25519;
    standard[OP_ACC]    = rand_opnd();
    standard[OP_FACTOR] = rand_opnd();
    standard[OP_BETA]   = beta25519;
    standard[OP_RMASK]  = '1;
    standard[OP_PN]     = {1'b0, {255{1'b1}}};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    for (int c = 0; c < 8; c++) load_operand(c[3:0], standard[c]);
    send(CMD_START, '0, '0);
    send(CMD_EXP, '0, 32'd1);
    send(CMD_START, '0, '0);
    load_operand(CMD_BASE, '1);
    send(CMD_FACTOR, 3'd7, '1);
    send(CMD_EXP, '0, 32'd5);
    send(CMD_START, '0, '0);
    send(CMD_RMASK, 3'd3, '0);
    send(CMD_START, '0, '0);
    send(CMD_RMASK, 3'd3, '1);
    send(4'd9, '0, '0);
    send(4'd15, 3'd7, '1);
    load_operand(CMD_EXP, '1);
    send(CMD_START, '0, '0);
    load_operand(CMD_EXP, '0);
    send(CMD_EXP, '0, 32'h8000_0003);

    for (int items = 0; items < 40; ) begin
      int writes;
      bool_restore: begin
        cmd = 4'd15;
        writes = $urandom_range(1, 4);
        repeat (writes) begin
          case ($urandom_range(0, 15))
            0, 1, 2: begin
              send(CMD_EXP, '0, $urandom & ((32'd1 << $urandom_range(1, 16)) - 32'd1));
              send(CMD_EXP, 3'd1, ($urandom_range(0, 15) == 0) ? $urandom : 32'd0);
              items += 2;
            end
            3: begin
              cmd = 4'($urandom_range(2, 7));
              if (cmd == CMD_EXP || cmd == CMD_ACC || cmd == CMD_FACTOR) cmd = CMD_PN;
              idx = 3'($urandom);
              send(cmd, idx, $urandom);
              items++;
            end
            4: begin
              send(4'($urandom_range(9, 15)), 3'($urandom), $urandom);
            end
            default: begin
              case ($urandom_range(0, 2))
                0: send(CMD_BASE, 3'($urandom), $urandom);
                1: send(CMD_ACC, 3'($urandom), $urandom);
                default: send(CMD_FACTOR, 3'($urandom), $urandom);
              endcase
              items++;
            end
          endcase
        end
        send(CMD_START, '0, '0);
        items++;
        if (cmd != 4'd15) begin
          send(cmd, idx, standard[cmd[2:0]][idx*WORD_BITS +: WORD_BITS]);
          items++;
        end
      end
    end
    in_ch.valid = 0;

    wait_left = 400000;
    while (sb.expected_words.size() != 0 && wait_left > 0) begin
      @(posedge clk);
      wait_left--;
    end
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0)
      $display("[montgomery_modexp_p25519] OK");
    else
      $display("[montgomery_modexp_p25519] ERROR");
    $finish;
  end
endmodule
